/* hw/rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the chunk cache directory.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/ccfd_pkg.sv */
// ---------------------------------------------------------------------------
// ccfd_pkg
// Types and constants shared by the chunk cache frequency directory.
// ---------------------------------------------------------------------------
package ccfd_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int TAG_W       = 16;
    localparam int CHUNK_W     = 16;
    localparam int CNT_W       = 16;
    localparam int SLOT_W      = 4;
    localparam int CFG_W       = 5;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int USED_W      = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W       = (USED_W > CFG_W) ? USED_W : CFG_W;
    localparam int IN_W        = 16;
    localparam int OUT_W       = 24;

    localparam logic [CFG_W-1:0] CAPACITY_RESET = CFG_W'(10);
    localparam logic [CNT_W-1:0] COUNT_MAX      = {CNT_W{1'b1}};

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [CNT_W-1:0]  cnt;
        logic [SLOT_W-1:0] slot;
    } entry_t;

    typedef struct packed {
        logic load_new;
        logic load_swap;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_PROMOTE
    } state_t;

endpackage

/* hw/rtl/ccfd_cell.sv */
// ---------------------------------------------------------------------------
// ccfd_cell
// One directory entry: tag compare, count compare and promotion run link.
// ---------------------------------------------------------------------------
module ccfd_cell
(
    input  logic                          clk,
    input  logic [ccfd_pkg::TAG_W-1:0]    req_tag,
    input  logic                          valid,
    input  logic [ccfd_pkg::CNT_W-1:0]    new_cnt,
    input  logic                          chain_in,
    input  logic                          run_below,
    input  ccfd_pkg::cell_ctl_t           ctl,
    input  ccfd_pkg::entry_t              new_entry,
    input  ccfd_pkg::entry_t              swap_entry,
    output logic                          match,
    output logic                          run,
    output logic                          head,
    output ccfd_pkg::entry_t              entry
);

    ccfd_pkg::entry_t entry_reg;

    assign match = valid && (entry_reg.tag == req_tag);
    assign run   = chain_in && (entry_reg.cnt < new_cnt);
    assign head  = run && !run_below;
    assign entry = entry_reg;

    always_ff @(posedge clk)
    begin
        priority if (ctl.load_new)
        begin
            entry_reg <= new_entry;
        end
        else if (ctl.load_swap)
        begin
            entry_reg <= swap_entry;
        end
    end

endmodule

/* hw/rtl/chunk_cache_frequency_directory_core.sv */
// ---------------------------------------------------------------------------
// chunk_cache_frequency_directory_core
// Frequency-ordered chunk directory built as a row of entry cells.
// ---------------------------------------------------------------------------
// A request moves through the accept, match and promote steps before its result word is registered.
// The next request is accepted only once the previous one has left the promote step.
// A new word is accepted while the previous result still waits in the output register.
// Reset: state, entry count and output valid clear; capacity returns to 10.
// Entry contents are not reset; entries beyond the entry count are never read.

`include "assert_macros.svh"

module chunk_cache_frequency_directory_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ccfd_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ccfd_pkg::IN_W-1:0]       s_tdata,   // [15:0] chunk_number
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ccfd_pkg::OUT_W-1:0]      m_tdata    // [0] hit, [4:1] buffer_slot,
                                                       // [5] evicted, [21:6] evicted_chunk
);

    localparam int N = ccfd_pkg::MAX_ENTRIES;

    ccfd_pkg::state_t                  state_reg, state_next;
    logic [ccfd_pkg::CFG_W-1:0]        cap_reg;
    logic [ccfd_pkg::USED_W-1:0]       used_reg, used_next;
    logic [ccfd_pkg::TAG_W-1:0]        tag_reg;
    logic [N-1:0]                      pos_oh_reg, pos_oh_next;
    ccfd_pkg::entry_t                  new_entry_reg, new_entry_next;
    logic                              hit_reg;
    logic                              evict_reg, evict_next;
    logic [ccfd_pkg::CHUNK_W-1:0]      old_tag_reg, old_tag_next;
    logic                              m_tvalid_reg;
    logic [ccfd_pkg::OUT_W-1:0]        m_tdata_reg;

    logic                              do_accept;
    logic                              do_match;
    logic                              do_promote;

    logic [N-1:0]                      cell_valid;
    logic [N-1:0]                      match_vec;
    logic [N-1:0]                      first_vec;
    logic [N-1:0]                      run_vec;
    logic [N-1:0]                      head_vec;
    logic [N-1:0]                      chain_in;
    logic [N-1:0]                      run_below;
    logic [N-1:0]                      dst_oh;
    logic [N-1:0]                      miss_oh;
    logic                              any_run;
    logic                              hit_now;
    logic                              append;
    logic [ccfd_pkg::USED_W-1:0]       cap_eff;
    logic [ccfd_pkg::IDX_W-1:0]        miss_pos;
    logic [ccfd_pkg::CNT_W-1:0]        old_cnt;
    logic [ccfd_pkg::SLOT_W-1:0]       slot_sel;
    ccfd_pkg::entry_t                  entries   [N];
    ccfd_pkg::cell_ctl_t               cell_ctl  [N];
    ccfd_pkg::entry_t                  sel_entry;
    ccfd_pkg::entry_t                  swap_entry;

    // -----------------------------------------------------------------------
    // cell row
    // -----------------------------------------------------------------------
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        assign cell_valid[i] = (ccfd_pkg::USED_W'(i) < used_reg);

        if (i == N - 1)
        begin : g_top
            assign chain_in[i] = 1'b0;
        end
        else
        begin : g_mid
            assign chain_in[i] = run_vec[i+1] | pos_oh_reg[i+1];
        end

        if (i == 0)
        begin : g_bot
            assign run_below[i] = 1'b0;
        end
        else
        begin : g_up
            assign run_below[i] = run_vec[i-1];
        end

        assign cell_ctl[i].load_new  = do_promote && dst_oh[i];
        assign cell_ctl[i].load_swap = do_promote && any_run && pos_oh_reg[i];

        ccfd_cell u_cell
        (
            .clk        (clk),
            .req_tag    (tag_reg),
            .valid      (cell_valid[i]),
            .new_cnt    (new_entry_reg.cnt),
            .chain_in   (chain_in[i]),
            .run_below  (run_below[i]),
            .ctl        (cell_ctl[i]),
            .new_entry  (new_entry_reg),
            .swap_entry (swap_entry),
            .match      (match_vec[i]),
            .run        (run_vec[i]),
            .head       (head_vec[i]),
            .entry      (entries[i])
        );
    end

    // -----------------------------------------------------------------------
    // match stage
    // -----------------------------------------------------------------------
    assign first_vec = match_vec & (~match_vec + N'(1));
    assign hit_now   = |match_vec;

    always_comb
    begin
        priority if (cap_reg == '0)
        begin
            cap_eff = ccfd_pkg::USED_W'(1);
        end
        else if (ccfd_pkg::CMP_W'(cap_reg) > ccfd_pkg::CMP_W'(N))
        begin
            cap_eff = ccfd_pkg::USED_W'(N);
        end
        else
        begin
            cap_eff = ccfd_pkg::USED_W'(cap_reg);
        end
    end

    assign append   = !hit_now && (used_reg < cap_eff);
    assign miss_pos = append ? ccfd_pkg::IDX_W'(used_reg)
                             : ccfd_pkg::IDX_W'(used_reg - ccfd_pkg::USED_W'(1));

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            miss_oh[i] = (miss_pos == ccfd_pkg::IDX_W'(i));
        end
    end

    assign pos_oh_next = hit_now ? first_vec : miss_oh;

    always_comb
    begin
        sel_entry = '0;
        for (int i = 0; i < N; i++)
        begin
            if (pos_oh_next[i])
            begin
                sel_entry = entries[i];
            end
        end
    end

    always_comb
    begin
        old_cnt      = hit_now ? sel_entry.cnt : '0;
        slot_sel     = append ? ccfd_pkg::SLOT_W'(miss_pos) : sel_entry.slot;
        evict_next   = !hit_now && !append;
        old_tag_next = evict_next ? ccfd_pkg::CHUNK_W'(sel_entry.tag) : '0;
        used_next    = append ? used_reg + ccfd_pkg::USED_W'(1) : used_reg;

        new_entry_next.tag  = tag_reg;
        new_entry_next.cnt  = (old_cnt == ccfd_pkg::COUNT_MAX) ? old_cnt
                                                               : old_cnt + ccfd_pkg::CNT_W'(1);
        new_entry_next.slot = slot_sel;
    end

    // -----------------------------------------------------------------------
    // promote stage
    // -----------------------------------------------------------------------
    assign any_run = |run_vec;
    assign dst_oh  = any_run ? head_vec : pos_oh_reg;

    always_comb
    begin
        swap_entry = '0;
        for (int i = 0; i < N; i++)
        begin
            if (dst_oh[i])
            begin
                swap_entry = entries[i];
            end
        end
    end

    // -----------------------------------------------------------------------
    // sequencer
    // -----------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ccfd_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ccfd_pkg::ST_MATCH;
                end
            end
            ccfd_pkg::ST_MATCH:
            begin
                state_next = ccfd_pkg::ST_PROMOTE;
            end
            ccfd_pkg::ST_PROMOTE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = ccfd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ccfd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready   = 1'b0;
        do_match   = 1'b0;
        do_promote = 1'b0;
        unique case (state_reg)
            ccfd_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ccfd_pkg::ST_MATCH:
            begin
                do_match = 1'b1;
            end
            ccfd_pkg::ST_PROMOTE:
            begin
                do_promote = !m_tvalid_reg || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign do_accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ccfd_pkg::ST_IDLE;
            cap_reg      <= ccfd_pkg::CAPACITY_RESET;
            used_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (do_match)
            begin
                used_reg <= used_next;
            end
            if (do_promote)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_accept)
        begin
            tag_reg <= ccfd_pkg::TAG_W'(s_tdata[ccfd_pkg::CHUNK_W-1:0]);
        end
        if (do_match)
        begin
            pos_oh_reg    <= pos_oh_next;
            new_entry_reg <= new_entry_next;
            hit_reg       <= hit_now;
            evict_reg     <= evict_next;
            old_tag_reg   <= old_tag_next;
        end
        if (do_promote)
        begin
            m_tdata_reg <= {2'b00, old_tag_reg, evict_reg, new_entry_reg.slot, hit_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // -----------------------------------------------------------------------
    // assertions
    // -----------------------------------------------------------------------
    `ASSERT_IMPL(a_used_bound, clk, rst_n, 1'b1,
                 ccfd_pkg::CMP_W'(used_reg) <= ccfd_pkg::CMP_W'(N),
                 "entry count above directory size")
    `ASSERT_IMPL(a_dst_onehot, clk, rst_n, state_reg == ccfd_pkg::ST_PROMOTE,
                 $onehot(dst_oh), "promotion target not one-hot")
    `ASSERT_NEXT(a_accept_match, clk, rst_n, do_accept,
                 state_reg == ccfd_pkg::ST_MATCH, "accepted word did not enter match")
    `ASSERT_IMPL(a_result_src, clk, rst_n, $rose(m_tvalid),
                 $past(do_promote), "result word without promotion")

endmodule

/* tb/tb_chunk_cache_frequency_directory_core.sv */
// ---------------------------------------------------------------------------
// tb_chunk_cache_frequency_directory_core
// Self-checking bench for the frequency-ordered chunk directory. A directed
// table covers reset state, fill, eviction and out-of-range capacities. Random
// phases then run hot-tag traffic under several capacities. Each result word is
// checked field by field against its table row or an in-bench directory model.
// ---------------------------------------------------------------------------
module tb_chunk_cache_frequency_directory_core;

    localparam int          PLAN_LEN    = 25;
    localparam int          PHASE_CNT   = 8;
    localparam int          PHASE_ITEMS = 150;
    localparam int          HOT_CNT     = 20;
    localparam int unsigned CYCLE_LIMIT = 60000;

    typedef struct packed {
        logic [1:0]                  pad;
        logic [ccfd_pkg::TAG_W-1:0]  evicted_chunk;
        logic                        evicted;
        logic [ccfd_pkg::SLOT_W-1:0] slot;
        logic                        hit;
    } lookup_t;

    typedef enum logic {
        ROW_CFG,
        ROW_REQ
    } row_kind_t;

    typedef struct packed {
        row_kind_t                 kind;
        logic [ccfd_pkg::IN_W-1:0] value;
        logic                      typed;
        lookup_t                   want;
    } directed_row_t;

    logic                           clk;
    logic                           rst_n     = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [ccfd_pkg::CFG_W-1:0]     cfg_wdata = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [ccfd_pkg::IN_W-1:0]      s_tdata   = '0;   // [15:0] chunk_number
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [ccfd_pkg::OUT_W-1:0]     m_tdata;          // [0] hit, [4:1] buffer_slot,
                                                      // [5] evicted, [21:6] evicted_chunk

    ccfd_pkg::entry_t               dir_model [ccfd_pkg::MAX_ENTRIES];
    int                             dir_used;
    logic [ccfd_pkg::CFG_W-1:0]     capacity_setting;
    lookup_t                        expected_lookups [$];

    bit                             steady = 1'b0;
    int                             errors;
    int unsigned                    cycle_count;
    int                             requests_sent;
    int                             hits_seen;
    int                             evictions_seen;
    int                             cfg_writes;

    chunk_cache_frequency_directory_core i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_lookups.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        m_tready <= steady || ($urandom_range(0, 99) >= 20);
    end

    function automatic lookup_t lk(input logic hit, input int slot, input logic evicted,
                                   input logic [ccfd_pkg::TAG_W-1:0] evicted_chunk);
        lookup_t r;
        r = '0;
        r.hit           = hit;
        r.slot          = ccfd_pkg::SLOT_W'(slot);
        r.evicted       = evicted;
        r.evicted_chunk = evicted_chunk;
        return r;
    endfunction

    // Look up one chunk, update the directory and return the result word.
    function automatic lookup_t predict_lookup(input logic [ccfd_pkg::IN_W-1:0] chunk);
        lookup_t          r;
        int               limit;
        int               pos;
        int               dst;
        bit               found;
        ccfd_pkg::entry_t held;
        r     = '0;
        found = 1'b0;
        pos   = 0;
        limit = (capacity_setting == 0) ? 1 :
                (capacity_setting > ccfd_pkg::MAX_ENTRIES) ? ccfd_pkg::MAX_ENTRIES :
                int'(capacity_setting);
        for (int i = 0; i < dir_used; i++)
        begin
            if (!found && dir_model[i].tag == ccfd_pkg::TAG_W'(chunk))
            begin
                found = 1'b1;
                pos   = i;
            end
        end
        if (found)
        begin
            r.hit = 1'b1;
        end
        else
        begin
            if (dir_used < limit)
            begin
                pos                 = dir_used;
                dir_model[pos].slot = ccfd_pkg::SLOT_W'(pos);
                dir_used            = dir_used + 1;
            end
            else
            begin
                pos             = dir_used - 1;
                r.evicted       = 1'b1;
                r.evicted_chunk = dir_model[pos].tag;
            end
            dir_model[pos].tag = ccfd_pkg::TAG_W'(chunk);
            dir_model[pos].cnt = '0;
        end
        if (dir_model[pos].cnt != ccfd_pkg::COUNT_MAX)
            dir_model[pos].cnt = dir_model[pos].cnt + 1'b1;
        dst = pos;
        while (dst > 0 && dir_model[dst-1].cnt < dir_model[pos].cnt)
            dst--;
        r.slot         = dir_model[pos].slot;
        held           = dir_model[pos];
        dir_model[pos] = dir_model[dst];
        dir_model[dst] = held;
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin : result_monitor
        lookup_t got;
        lookup_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (expected_lookups.size() == 0)
            begin
                $error("result word 0x%0h with nothing outstanding", m_tdata);
                errors++;
            end
            else
            begin
                want = expected_lookups.pop_front();
                check_field("hit", want.hit, got.hit);
                check_field("buffer_slot", want.slot, got.slot);
                check_field("evicted", want.evicted, got.evicted);
                check_field("evicted_chunk", want.evicted_chunk, got.evicted_chunk);
                check_field("padding", want.pad, got.pad);
                if (got.hit)
                    hits_seen++;
                if (got.evicted)
                    evictions_seen++;
            end
        end
    end

    task automatic send_request(input logic [ccfd_pkg::IN_W-1:0] chunk, input logic typed,
                                input lookup_t want);
        lookup_t predicted;
        while (!steady && $urandom_range(0, 99) < 20)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= chunk;
        do
            @(posedge clk);
        while (!s_tready);
        predicted = predict_lookup(chunk);
        expected_lookups.push_back(typed ? want : predicted);
        requests_sent++;
    endtask

    // Drain all outstanding words, then write the capacity register.
    task automatic write_capacity(input logic [ccfd_pkg::CFG_W-1:0] value);
        s_tvalid <= 1'b0;
        while (expected_lookups.size() != 0)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we           <= 1'b0;
        capacity_setting  = value;
        cfg_writes++;
    endtask

    initial
    begin : stimulus
        directed_row_t              plan [PLAN_LEN];
        logic [ccfd_pkg::CFG_W-1:0] phase_caps [PHASE_CNT];
        logic [ccfd_pkg::IN_W-1:0]  hot_tags [HOT_CNT];
        logic [ccfd_pkg::IN_W-1:0]  chunk;
        int                         pick;

        dir_used         = 0;
        capacity_setting = ccfd_pkg::CAPACITY_RESET;

        plan = '{
            '{ROW_REQ, 16'h0000, 1'b1, lk(1'b0, 0, 1'b0, 16'h0000)},
            '{ROW_REQ, 16'hFFFF, 1'b1, lk(1'b0, 1, 1'b0, 16'h0000)},
            '{ROW_REQ, 16'hFFFF, 1'b1, lk(1'b1, 1, 1'b0, 16'h0000)},
            '{ROW_REQ, 16'h0000, 1'b1, lk(1'b1, 0, 1'b0, 16'h0000)},
            '{ROW_REQ, 16'h0001, 1'b0, '0},
            '{ROW_REQ, 16'h0002, 1'b0, '0},
            '{ROW_REQ, 16'h0003, 1'b0, '0},
            '{ROW_REQ, 16'h0004, 1'b0, '0},
            '{ROW_REQ, 16'h0005, 1'b0, '0},
            '{ROW_REQ, 16'h0006, 1'b0, '0},
            '{ROW_REQ, 16'h0007, 1'b0, '0},
            '{ROW_REQ, 16'h0008, 1'b0, '0},
            '{ROW_REQ, 16'h5555, 1'b1, lk(1'b0, 9, 1'b1, 16'h0008)},
            '{ROW_REQ, 16'hAAAA, 1'b1, lk(1'b0, 9, 1'b1, 16'h5555)},
            '{ROW_CFG, 16'd0,    1'b0, '0},
            '{ROW_REQ, 16'h1234, 1'b0, '0},
            '{ROW_REQ, 16'h0007, 1'b0, '0},
            '{ROW_CFG, 16'd31,   1'b0, '0},
            '{ROW_REQ, 16'h8001, 1'b0, '0},
            '{ROW_REQ, 16'h4002, 1'b0, '0},
            '{ROW_REQ, 16'h2004, 1'b0, '0},
            '{ROW_REQ, 16'h1008, 1'b0, '0},
            '{ROW_REQ, 16'h0810, 1'b0, '0},
            '{ROW_REQ, 16'h0420, 1'b0, '0},
            '{ROW_REQ, 16'hF00F, 1'b0, '0}
        };
        phase_caps = '{5'd16, 5'd3, 5'd31, 5'd0, 5'd1, 5'd7, 5'd0, 5'd10};
        phase_caps[6] = ccfd_pkg::CFG_W'($urandom_range(2, 15));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
                write_capacity(plan[i].value[ccfd_pkg::CFG_W-1:0]);
            else
                send_request(plan[i].value, plan[i].typed, plan[i].want);
        end

        for (int p = 0; p < PHASE_CNT; p++)
        begin
            write_capacity(phase_caps[p]);
            steady = (p == 0);
            foreach (hot_tags[h])
                hot_tags[h] = ccfd_pkg::IN_W'($urandom());
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 75)
                    chunk = hot_tags[$urandom_range(0, $urandom_range(0, HOT_CNT - 1))];
                else
                    chunk = ccfd_pkg::IN_W'($urandom());
                send_request(chunk, 1'b0, '0);
            end
        end

        s_tvalid <= 1'b0;
        while (expected_lookups.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Ran %0d requests (%0d hits, %0d evictions) over %0d capacity writes,",
                 requests_sent, hits_seen, evictions_seen, cfg_writes);
        $display("covering fill, eviction, zero and oversized capacities and hot-tag mixes.");
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
